>>> src/decision_tree_leaf_lookup_top_defines.svh
// Assertion macros shared by the RTL
`ifndef DECISION_TREE_LEAF_LOOKUP_TOP_DEFINES_SVH
`define DECISION_TREE_LEAF_LOOKUP_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define DTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/dtl_pkg.sv
`default_nettype none
package dtl_pkg;
	localparam int FIELD_W = 32;
	localparam int FEAT_W = 8;
	localparam int NIDX_W = 10;
	localparam int CFG_W = 9;
	localparam logic [8:0] FEATURE_COUNT_RST = 9'd256;

	typedef enum logic [1:0] {
		OP_WRITE_NODE = 2'd0,
		OP_SET_FEATURE = 2'd1,
		OP_MISS_FEATURE = 2'd2,
		OP_PREDICT = 2'd3
	} opcode_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;   // capture input item, do feature/node writes
		logic issue_read;  // latch out-of-range flag for the node read at current index
		logic step;        // evaluate returned node, advance
		logic load_out;    // load output register
	} dtl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_predict;
		logic at_leaf;
		logic limit_hit;
	} dtl_status_t;

	// IEEE single ordering, NaN and signed zero never less
	function automatic logic f32_less(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ka;
		logic [31:0] kb;
		logic nan_a;
		logic nan_b;
		ka = a[31] ? ~a : (a | 32'h8000_0000);
		kb = b[31] ? ~b : (b | 32'h8000_0000);
		nan_a = (a[30:0] > 31'h7F80_0000);
		nan_b = (b[30:0] > 31'h7F80_0000);
		if (nan_a || nan_b) return 1'b0;
		if ((a[30:0] | b[30:0]) == 31'd0) return 1'b0;
		return ka < kb;
	endfunction
endpackage
`default_nettype wire

>>> src/dtl_ram.sv
`default_nettype none
module dtl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> src/dtl_ctrl.sv
`default_nettype none
`include "decision_tree_leaf_lookup_top_defines.svh"
module dtl_ctrl
	import dtl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_fire,
	input  wire logic        out_busy,
	input  wire dtl_status_t status,
	output      logic        s_ready,
	output      dtl_cmd_t    cmd
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_WAIT,
		ST_EVAL,
		ST_OUT
	} state_t;

	state_t state_q;

	assign s_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load_item = in_fire;
		cmd.issue_read = (state_q == ST_READ);
		cmd.step = (state_q == ST_EVAL) && !status.at_leaf && !status.limit_hit;
		cmd.load_out = (state_q == ST_OUT) && !out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_DECODE;
				ST_DECODE: state_q <= status.is_predict ? ST_READ : ST_IDLE;
				ST_READ: state_q <= ST_WAIT;
				ST_WAIT: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (status.at_leaf || status.limit_hit) state_q <= ST_OUT;
					else state_q <= ST_READ;
				end
				ST_OUT: if (!out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`DTL_ASSERT_IMP(a_ready_idle, clk, arst_n, s_ready, state_q == ST_IDLE, "ready outside idle")
	`DTL_ASSERT_NEXT(a_fire_decode, clk, arst_n, in_fire, state_q == ST_DECODE, "no decode after item")
	`DTL_ASSERT_IMP(a_step_excl, clk, arst_n, cmd.step, !cmd.load_out && !cmd.issue_read, "step overlaps")
endmodule
`default_nettype wire

>>> src/dtl_datapath.sv
`default_nettype none
`include "decision_tree_leaf_lookup_top_defines.svh"
module dtl_datapath
	import dtl_pkg::*;
#(
	parameter int NODE_COUNT = 1024,
	parameter int FEATURE_SLOTS = 256,
	parameter int MAX_WALK = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire dtl_cmd_t     cmd,
	output      dtl_status_t  status,
	input  wire logic         cfg_we,
	input  wire logic [8:0]   cfg_data,
	input  wire logic [1:0]   opcode,
	input  wire logic [9:0]   node_index,
	input  wire logic         is_leaf_node,
	input  wire logic [9:0]   left_child,
	input  wire logic [9:0]   right_child,
	input  wire logic [7:0]   split_feature,
	input  wire logic         missing_goes_left,
	input  wire logic [31:0]  node_value,
	input  wire logic [7:0]   feature_index,
	input  wire logic [31:0]  feature_value,
	input  wire logic [9:0]   root_index,
	output      logic [9:0]   res_leaf_index,
	output      logic [31:0]  res_leaf_val,
	output      logic         res_status
);
	localparam int NA_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int FA_W = (FEATURE_SLOTS > 1) ? $clog2(FEATURE_SLOTS) : 1;
	localparam int WK_W = $clog2(MAX_WALK + 1);
	localparam int NODE_W = 62;

	logic [8:0]  feat_cnt_q;
	logic        predict_q;
	logic [9:0]  cur_q;
	logic [WK_W-1:0] steps_q;
	logic [FEATURE_SLOTS-1:0] present_q;

	// node word: {leaf, left, right, feature, dleft, value}
	logic              node_we;
	logic [NA_W-1:0]   node_waddr;
	logic [NODE_W-1:0] node_wdata;
	logic [NODE_W-1:0] node_rdata;
	logic [NA_W-1:0]   node_raddr;
	logic              cur_oob_q;

	logic              fv_we;
	logic [FA_W-1:0]   fv_waddr;
	logic [FA_W-1:0]   fv_raddr;
	logic [31:0]       fv_rdata;

	logic        n_leaf;
	logic [9:0]  n_left;
	logic [9:0]  n_right;
	logic [7:0]  n_feat;
	logic        n_dleft;
	logic [31:0] n_value;
	logic        f_usable;
	logic        f_present;
	logic        go_left;
	logic        feat_usable_in;
	logic [FEATURE_SLOTS-1:0] present_next;

	assign feat_usable_in = ({1'b0, feature_index} < feat_cnt_q)
		&& (32'(feature_index) < 32'(FEATURE_SLOTS));

	assign node_we = cmd.load_item && (opcode == OP_WRITE_NODE)
		&& (32'(node_index) < 32'(NODE_COUNT));
	assign node_waddr = NA_W'(node_index);
	assign node_wdata = {is_leaf_node, left_child, right_child, split_feature,
		missing_goes_left, node_value};
	assign node_raddr = NA_W'(cur_q);

	assign fv_we = cmd.load_item && (opcode == OP_SET_FEATURE) && feat_usable_in;
	assign fv_waddr = FA_W'(feature_index);

	dtl_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.raddr(node_raddr), .rdata(node_rdata)
	);

	// feature read address taken combinationally from the node word's feature field
	assign fv_raddr = FA_W'(node_rdata[40:33]);

	dtl_ram #(.WIDTH(32), .DEPTH(FEATURE_SLOTS)) u_feat_ram (
		.clk(clk), .we(fv_we), .waddr(fv_waddr), .wdata(feature_value),
		.raddr(fv_raddr), .rdata(fv_rdata)
	);

	// out-of-range node reads as all zero
	assign {n_leaf, n_left, n_right, n_feat, n_dleft, n_value} =
		cur_oob_q ? '0 : node_rdata;

	assign f_usable = ({1'b0, n_feat} < feat_cnt_q) && (32'(n_feat) < 32'(FEATURE_SLOTS));
	assign f_present = f_usable && present_q[FA_W'(n_feat)];
	assign go_left = f_present ? f32_less(fv_rdata, n_value) : n_dleft;

	assign status.is_predict = predict_q;
	assign status.at_leaf = n_leaf;
	assign status.limit_hit = (steps_q == WK_W'(MAX_WALK - 1)) && !n_leaf;

	always_comb begin
		present_next = present_q;
		if (cmd.load_item && feat_usable_in) begin
			if (opcode == OP_SET_FEATURE) present_next[FA_W'(feature_index)] = 1'b1;
			else if (opcode == OP_MISS_FEATURE) present_next[FA_W'(feature_index)] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feat_cnt_q <= FEATURE_COUNT_RST;
			present_q <= '0;
			predict_q <= 1'b0;
			steps_q <= '0;
		end else begin
			if (cfg_we) feat_cnt_q <= cfg_data;
			present_q <= present_next;
			if (cmd.load_item) begin
				predict_q <= (opcode == OP_PREDICT);
				steps_q <= '0;
			end else if (cmd.step) begin
				steps_q <= steps_q + WK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) cur_q <= root_index;
		else if (cmd.step) cur_q <= go_left ? n_left : n_right;
		if (cmd.issue_read) cur_oob_q <= !(32'(cur_q) < 32'(NODE_COUNT));
		if (cmd.load_out) begin
			res_leaf_index <= n_leaf ? cur_q : 10'd0;
			res_leaf_val <= n_leaf ? n_value : 32'd0;
			res_status <= !n_leaf;
		end
	end

	`DTL_ASSERT_IMP(a_step_bound, clk, arst_n, cmd.step, steps_q < WK_W'(MAX_WALK - 1), "walk past limit")
	`DTL_ASSERT_NEXT(a_step_count, clk, arst_n, cmd.step && !cmd.load_item, steps_q == $past(steps_q) + WK_W'(1), "step count")
	`DTL_ASSERT_IMP(a_no_wr_walk, clk, arst_n, cmd.step, !node_we && !fv_we, "write during walk")
endmodule
`default_nettype wire

>>> src/decision_tree_leaf_lookup_top.sv
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: opcode,node_index,is_leaf_node,left_child,right_child,
//                split_feature,missing_goes_left,node_value,feature_index,
//                feature_value,root_index
// m_axis    out  tdata: leaf_index,leaf_val,walk_status
// cfg       in   feature_count, written when cfg_we high
// A write returns to idle after decode. A predict passes read, wait and
// eval per tree level, node RAM then feature RAM read (max MAX_WALK), then out.
// Reset clears feature present marks, feature_count to 256 and the FSM;
// the node store is not cleared. Output register holds until taken; a
// predict whose result finds it still full waits in its last state with
// s_axis_tready low.
`default_nettype none
module decision_tree_leaf_lookup_top
	import dtl_pkg::*;
#(
	parameter int NODE_COUNT = 1024,
	parameter int FEATURE_SLOTS = 256,
	parameter int MAX_WALK = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [8:0]   cfg_data,
	input  wire logic         s_axis_tvalid,
	output      logic         s_axis_tready,
	// opcode[1:0] node_index[11:2] is_leaf_node[12] left_child[22:13]
	// right_child[32:23] split_feature[40:33] missing_goes_left[41]
	// node_value[73:42] feature_index[81:74] feature_value[113:82]
	// root_index[123:114], zero fill to 128
	input  wire logic [127:0] s_axis_tdata,
	output      logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// leaf_index[9:0] leaf_val[41:10] walk_status[42], zero fill to 48
	output      logic [47:0]  m_axis_tdata
);
	dtl_cmd_t    cmd;
	dtl_status_t status;
	logic        in_fire;
	logic        out_valid_q;
	logic [9:0]  r_idx;
	logic [31:0] r_val;
	logic        r_st;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	dtl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(out_valid_q && !m_axis_tready), .status(status),
		.s_ready(s_axis_tready), .cmd(cmd)
	);

	dtl_datapath #(
		.NODE_COUNT(NODE_COUNT), .FEATURE_SLOTS(FEATURE_SLOTS), .MAX_WALK(MAX_WALK)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.opcode(s_axis_tdata[1:0]), .node_index(s_axis_tdata[11:2]),
		.is_leaf_node(s_axis_tdata[12]), .left_child(s_axis_tdata[22:13]),
		.right_child(s_axis_tdata[32:23]), .split_feature(s_axis_tdata[40:33]),
		.missing_goes_left(s_axis_tdata[41]), .node_value(s_axis_tdata[73:42]),
		.feature_index(s_axis_tdata[81:74]), .feature_value(s_axis_tdata[113:82]),
		.root_index(s_axis_tdata[123:114]),
		.res_leaf_index(r_idx), .res_leaf_val(r_val), .res_status(r_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_out) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'd0, r_st, r_val, r_idx};
endmodule
`default_nettype wire
